@@ rtl/mcst_pkg.sv @@
// ----------------------------------------------------------------------------
// mcst_pkg: shared types and constants for the minimal carrier-set table
// Entry layout, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package mcst_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int SET_BITS    = 128;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // valid bits of the upper carrier word
   localparam logic [63:0] HIGH_MASK = {64{1'b1}} >> (128 - SET_BITS);

   typedef logic [3:0] kind_type;
   localparam kind_type KIND_ADD       = 4'd0;
   localparam kind_type KIND_FORCE_ADD = 4'd1;
   localparam kind_type KIND_RM_EXACT  = 4'd2;
   localparam kind_type KIND_RM_SUPER  = 4'd3;
   localparam kind_type KIND_RM_HIT    = 4'd4;
   localparam kind_type KIND_SUPER_TST = 4'd5;
   localparam kind_type KIND_SUB_TST   = 4'd6;
   localparam kind_type KIND_UNION     = 4'd7;
   localparam kind_type KIND_GREEDY    = 4'd8;
   localparam kind_type KIND_ISECT     = 4'd9;
   localparam kind_type KIND_KF_ISECT  = 4'd10;

   typedef logic [1:0] status_type;
   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_FALSE = 2'd1;
   localparam status_type STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] hi;
      logic [6:0]  key;
      logic [2:0]  rule;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // relations between the stored entry and the query
   typedef struct packed {
      logic e_sub_q;
      logic q_sub_e;
      logic hit;
      logic exact;
   } cmp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_COMPACT,
      S_MTF,
      S_MTF_HEAD,
      S_APPEND,
      S_RESP
   } state_type;

endpackage

@@ rtl/minimal_carrier_set_table.sv @@
// ----------------------------------------------------------------------------
// minimal_carrier_set_table: subset-minimal table of carrier sets
// Ordered table of up to TABLE_DEPTH entries with add, remove, test and
// union/intersection operations, worked by a sequencer over one comparator.
// ----------------------------------------------------------------------------
// Usage:
//  - Issue a transaction by raising start with the req_ fields while busy is
//    low; the request is taken at that clock edge and busy rises.
//  - Results appear on the rsp_ ports for one cycle each, flagged by
//    rsp_strobe; rsp_last marks the final result of the transaction. The
//    receiver cannot stall, so results are never held.
//  - Entries live in one RAM, read and written one entry at a time by the
//    sequencer (a read cycle, then a compare-and-write cycle).
//  - Add and the removals make a compaction pass over the table; move to
//    front shifts the entries ahead of the hit down one place, one by one.
//  - Remove-hitting-mask first counts hits, then emits one result per
//    removed entry, in table order, during the compaction pass.
//  - Reset empties the table at once (count cleared); no clearing pass.
// ----------------------------------------------------------------------------
module minimal_carrier_set_table import mcst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_kind,
   input  logic [63:0] req_carrier_low,
   input  logic [63:0] req_carrier_high,
   input  logic [6:0]  req_key_cell,
   input  logic [2:0]  req_rule_code,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_removed_count,
   output logic [63:0] rsp_set_low,
   output logic [63:0] rsp_set_high,
   output logic [6:0]  rsp_out_key,
   output logic [2:0]  rsp_out_rule,
   output logic        rsp_last
);

   state_type   state_ff, state_in;
   logic        ph_ff;
   logic [CNT_W-1:0] idx_ff, wr_ff, cnt_ff, n_ff, k_ff;
   logic        found_ff;
   kind_type    kind_ff;
   logic [63:0] q_lo_ff, q_hi_ff;
   logic [6:0]  q_key_ff;
   logic [2:0]  q_rule_ff;
   entry_type   e_ff;
   logic [63:0] acc_lo_ff, acc_hi_ff, iacc_lo_ff, iacc_hi_ff;
   logic [6:0]  res_key_ff;
   logic [2:0]  res_rule_ff;
   status_type  stat_ff;

   logic [63:0] acc_lo_nx, acc_hi_nx, iacc_lo_nx, iacc_hi_nx;
   cmp_type     flags;
   entry_type   rd_ent, wr_ent;
   logic [ENTRY_W-1:0] rd_data;
   logic        wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   logic scan_end, scan_stop, rem, emit, full, accum_kind;

   mcst_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_ent = entry_type'(rd_data);

   mcst_cmp u_cmp (
      .kind       (kind_ff),
      .q_lo       (q_lo_ff),
      .q_hi       (q_hi_ff),
      .q_key      (q_key_ff),
      .ent        (rd_ent),
      .acc_lo     (acc_lo_ff),
      .acc_hi     (acc_hi_ff),
      .iacc_lo    (iacc_lo_ff),
      .iacc_hi    (iacc_hi_ff),
      .flags      (flags),
      .acc_lo_nx  (acc_lo_nx),
      .acc_hi_nx  (acc_hi_nx),
      .iacc_lo_nx (iacc_lo_nx),
      .iacc_hi_nx (iacc_hi_nx)
   );

   assign scan_end   = (idx_ff == cnt_ff);
   assign full       = (cnt_ff >= CNT_W'(TABLE_DEPTH));
   assign accum_kind = (kind_ff == KIND_UNION) || (kind_ff == KIND_GREEDY) ||
                       (kind_ff == KIND_ISECT) || (kind_ff == KIND_KF_ISECT);

   // scan halts on the first entry that answers the query
   assign scan_stop = (((kind_ff == KIND_ADD) || (kind_ff == KIND_SUPER_TST)) &&
                       flags.e_sub_q) ||
                      ((kind_ff == KIND_SUB_TST) && flags.q_sub_e);

   // entry dropped during compaction
   always_comb begin
      case (kind_ff)
         KIND_ADD,
         KIND_RM_SUPER: rem = flags.q_sub_e;
         KIND_RM_EXACT: rem = !found_ff && flags.exact;
         KIND_RM_HIT:   rem = flags.hit;
         default:       rem = 1'b0;
      endcase
   end

   assign emit = (state_ff == S_COMPACT) && ph_ff && rem && (kind_ff == KIND_RM_HIT);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_kind)
                  KIND_ADD, KIND_RM_HIT, KIND_SUPER_TST, KIND_SUB_TST,
                  KIND_UNION, KIND_GREEDY, KIND_ISECT, KIND_KF_ISECT:
                     state_in = S_SCAN;
                  KIND_FORCE_ADD: state_in = full ? S_RESP : S_APPEND;
                  KIND_RM_EXACT, KIND_RM_SUPER: state_in = S_COMPACT;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_SCAN: begin
            if (!ph_ff && scan_end) begin
               if (kind_ff == KIND_ADD) begin
                  state_in = S_COMPACT;
               end else if (kind_ff == KIND_RM_HIT && n_ff != '0) begin
                  state_in = S_COMPACT;
               end else begin
                  state_in = S_RESP;
               end
            end else if (ph_ff && scan_stop) begin
               state_in = (kind_ff == KIND_SUB_TST) ? S_RESP : S_MTF;
            end
         end
         S_COMPACT: begin
            if (!ph_ff && scan_end) begin
               case (kind_ff)
                  KIND_ADD:    state_in = (wr_ff >= CNT_W'(TABLE_DEPTH)) ? S_RESP
                                                                          : S_APPEND;
                  KIND_RM_HIT: state_in = S_IDLE;
                  default:     state_in = S_RESP;
               endcase
            end
         end
         S_MTF: begin
            if (!ph_ff && idx_ff == '0) begin
               state_in = S_MTF_HEAD;
            end
         end
         S_MTF_HEAD: state_in = S_RESP;
         S_APPEND:   state_in = S_RESP;
         S_RESP:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs: RAM control and result ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ADDR_W'(wr_ff);
      wr_ent  = rd_ent;
      rd_addr = ADDR_W'(idx_ff);
      case (state_ff)
         S_COMPACT: begin
            wr_en = ph_ff && !rem;
         end
         S_MTF: begin
            rd_addr = ADDR_W'(idx_ff - CNT_W'(1));
            wr_addr = ADDR_W'(idx_ff);
            wr_en   = ph_ff;
         end
         S_MTF_HEAD: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_ent  = e_ff;
         end
         S_APPEND: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(cnt_ff);
            wr_ent  = '{lo: q_lo_ff, hi: q_hi_ff, key: q_key_ff, rule: q_rule_ff};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase

      rsp_strobe        = (state_ff == S_RESP) || emit;
      rsp_removed_count = 6'(n_ff);
      if (emit) begin
         rsp_status   = STAT_OK;
         rsp_set_low  = rd_ent.lo;
         rsp_set_high = rd_ent.hi;
         rsp_out_key  = rd_ent.key;
         rsp_out_rule = rd_ent.rule;
         rsp_last     = ((k_ff + CNT_W'(1)) == n_ff);
      end else begin
         rsp_status   = stat_ff;
         rsp_set_low  = acc_lo_ff;
         rsp_set_high = acc_hi_ff;
         rsp_out_key  = res_key_ff;
         rsp_out_rule = res_rule_ff;
         rsp_last     = 1'b1;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         ph_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_IDLE:    ph_ff <= 1'b0;
            S_SCAN, S_COMPACT, S_MTF: begin
               // alternate read and compare cycles; restart on leaving
               if (state_in != state_ff) begin
                  ph_ff <= 1'b0;
               end else begin
                  ph_ff <= !ph_ff;
               end
               if (state_ff == S_COMPACT && !ph_ff && scan_end) begin
                  cnt_ff <= wr_ff;
               end
            end
            S_APPEND:  cnt_ff <= cnt_ff + CNT_W'(1);
            default:   ph_ff <= 1'b0;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            kind_ff     <= req_kind;
            q_lo_ff     <= req_carrier_low;
            q_hi_ff     <= req_carrier_high & HIGH_MASK;
            q_key_ff    <= req_key_cell;
            q_rule_ff   <= req_rule_code;
            idx_ff      <= '0;
            wr_ff       <= '0;
            n_ff        <= '0;
            k_ff        <= '0;
            found_ff    <= 1'b0;
            res_key_ff  <= '0;
            res_rule_ff <= '0;
            iacc_lo_ff  <= {64{1'b1}};
            iacc_hi_ff  <= HIGH_MASK;
            if (req_kind == KIND_ISECT || req_kind == KIND_KF_ISECT) begin
               acc_lo_ff <= {64{1'b1}};
               acc_hi_ff <= HIGH_MASK;
            end else begin
               acc_lo_ff <= '0;
               acc_hi_ff <= '0;
            end
            if (req_kind == KIND_FORCE_ADD && full) begin
               stat_ff <= STAT_FULL;
            end else if (req_kind > KIND_KF_ISECT) begin
               stat_ff <= STAT_FALSE;
            end else begin
               stat_ff <= STAT_OK;
            end
         end
         S_SCAN: begin
            if (!ph_ff && scan_end) begin
               // nothing matched: tests fail
               if (kind_ff == KIND_SUPER_TST || kind_ff == KIND_SUB_TST) begin
                  stat_ff <= STAT_FALSE;
               end
               idx_ff <= '0;
            end else if (ph_ff) begin
               if (!scan_stop) begin
                  idx_ff <= idx_ff + CNT_W'(1);
               end
               if (accum_kind) begin
                  acc_lo_ff  <= acc_lo_nx;
                  acc_hi_ff  <= acc_hi_nx;
                  iacc_lo_ff <= iacc_lo_nx;
                  iacc_hi_ff <= iacc_hi_nx;
               end
               if (kind_ff == KIND_RM_HIT && flags.hit) begin
                  n_ff <= n_ff + CNT_W'(1);
               end
               if (scan_stop) begin
                  // hold the hit and its index for move to front
                  e_ff <= rd_ent;
                  if (kind_ff == KIND_ADD) begin
                     stat_ff <= STAT_FALSE;
                  end
               end
            end
         end
         S_COMPACT: begin
            if (!ph_ff && scan_end) begin
               if (kind_ff == KIND_ADD && wr_ff >= CNT_W'(TABLE_DEPTH)) begin
                  stat_ff <= STAT_FULL;
               end
               if (kind_ff == KIND_RM_EXACT && !found_ff) begin
                  stat_ff <= STAT_FALSE;
               end
            end else if (ph_ff) begin
               idx_ff <= idx_ff + CNT_W'(1);
               if (rem) begin
                  if (kind_ff == KIND_RM_HIT) begin
                     k_ff <= k_ff + CNT_W'(1);
                  end else begin
                     n_ff <= n_ff + CNT_W'(1);
                  end
                  if (kind_ff == KIND_RM_EXACT) begin
                     found_ff    <= 1'b1;
                     acc_lo_ff   <= rd_ent.lo;
                     acc_hi_ff   <= rd_ent.hi;
                     res_key_ff  <= rd_ent.key;
                     res_rule_ff <= rd_ent.rule;
                  end
               end else begin
                  wr_ff <= wr_ff + CNT_W'(1);
               end
            end
         end
         S_MTF: begin
            if (ph_ff) begin
               idx_ff <= idx_ff - CNT_W'(1);
            end
         end
         default: begin
            idx_ff <= idx_ff;
         end
      endcase
   end

endmodule

@@ rtl/mcst_ram.sv @@
// ----------------------------------------------------------------------------
// mcst_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mcst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mcst_cmp.sv @@
// ----------------------------------------------------------------------------
// mcst_cmp: shared set comparator and accumulator
// Compares one stored entry against the query and folds it into the running
// union or intersection.
// ----------------------------------------------------------------------------
module mcst_cmp import mcst_pkg::*; (
   input  kind_type    kind,
   input  logic [63:0] q_lo,
   input  logic [63:0] q_hi,
   input  logic [6:0]  q_key,
   input  entry_type   ent,
   input  logic [63:0] acc_lo,
   input  logic [63:0] acc_hi,
   input  logic [63:0] iacc_lo,
   input  logic [63:0] iacc_hi,
   output cmp_type     flags,
   output logic [63:0] acc_lo_nx,
   output logic [63:0] acc_hi_nx,
   output logic [63:0] iacc_lo_nx,
   output logic [63:0] iacc_hi_nx
);

   logic [63:0] c_lo;
   logic [63:0] c_hi;
   logic [63:0] k_lo;
   logic [63:0] k_hi;

   always_comb begin
      flags.e_sub_q = ((ent.lo & ~q_lo) == '0) && ((ent.hi & ~q_hi) == '0);
      flags.q_sub_e = ((q_lo & ~ent.lo) == '0) && ((q_hi & ~ent.hi) == '0);
      flags.hit     = ((ent.lo & q_lo) != '0) || ((ent.hi & q_hi) != '0);
      flags.exact   = (ent.lo == q_lo) && (ent.hi == q_hi) && (ent.key == q_key);

      c_lo = iacc_lo & ent.lo;
      c_hi = iacc_hi & ent.hi;

      // clear the entry's own key bit for the key-free intersection
      k_lo = ent.lo;
      k_hi = ent.hi;
      if ({1'b0, ent.key} < 8'(SET_BITS)) begin
         if (!ent.key[6]) begin
            k_lo = ent.lo & ~(64'd1 << ent.key[5:0]);
         end else begin
            k_hi = ent.hi & ~(64'd1 << ent.key[5:0]);
         end
      end

      acc_lo_nx  = acc_lo;
      acc_hi_nx  = acc_hi;
      iacc_lo_nx = iacc_lo;
      iacc_hi_nx = iacc_hi;
      case (kind)
         KIND_UNION: begin
            acc_lo_nx = acc_lo | ent.lo;
            acc_hi_nx = acc_hi | ent.hi;
         end
         KIND_GREEDY: begin
            if (c_lo != iacc_lo || c_hi != iacc_hi) begin
               acc_lo_nx  = acc_lo | ent.lo;
               acc_hi_nx  = acc_hi | ent.hi;
               iacc_lo_nx = c_lo;
               iacc_hi_nx = c_hi;
            end
         end
         KIND_ISECT: begin
            acc_lo_nx = acc_lo & ent.lo;
            acc_hi_nx = acc_hi & ent.hi;
         end
         KIND_KF_ISECT: begin
            acc_lo_nx = acc_lo & k_lo;
            acc_hi_nx = acc_hi & k_hi;
         end
         default: begin
            acc_lo_nx = acc_lo;
         end
      endcase
   end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for minimal_carrier_set_table
// Drives add, remove, test and union/intersection transactions through the
// start/busy handshake and checks every strobed result against a mirror of
// the table kept in a scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
   import mcst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int       CYCLE_LIMIT   = 1000000;
   localparam int       SETTLE_CYCLES = 250;     // longer than a full add on a full table
   localparam int       RANDOM_ITEMS  = 350;
   localparam kind_type KIND_TOP      = KIND_KF_ISECT; // codes above this are invalid and answered with STAT_FALSE

   typedef struct {
      status_type  status;
      logic [5:0]  removed;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [6:0]  key;
      logic [2:0]  rule;
      logic        last;
   } rsp_item_type;

   // Mirror of the table plus the queue of results it predicts
   class carrier_table_scoreboard;
      logic [63:0] tab_lo[TABLE_DEPTH];
      logic [63:0] tab_hi[TABLE_DEPTH];
      logic [6:0]  tab_key[TABLE_DEPTH];
      logic [2:0]  tab_rule[TABLE_DEPTH];
      int          fill;
      int          mismatches;
      rsp_item_type pending_rsp[$];

      function new();
         fill = 0;
         mismatches = 0;
      endfunction

      function void report_mismatch(string what);
         $display("mismatch @%0t: %s", $realtime, what);
         mismatches++;
      endfunction

      function bit subset_of(logic [63:0] alo, logic [63:0] ahi,
                             logic [63:0] blo, logic [63:0] bhi);
         return ((alo & ~blo) == 64'd0) && ((ahi & ~bhi) == 64'd0);
      endfunction

      function void queue_rsp(status_type st, int cnt, logic [63:0] lo, logic [63:0] hi,
                              logic [6:0] key, logic [2:0] rule, bit last);
         rsp_item_type r;
         r.status  = st;
         r.removed = cnt[5:0];
         r.lo      = lo;
         r.hi      = hi;
         r.key     = key;
         r.rule    = rule;
         r.last    = last;
         pending_rsp = {pending_rsp, r};
      endfunction

      function void move_to_head(int i);
         logic [63:0] lo;
         logic [63:0] hi;
         logic [6:0]  key;
         logic [2:0]  rule;
         lo = tab_lo[i]; hi = tab_hi[i]; key = tab_key[i]; rule = tab_rule[i];
         for (int j = i; j > 0; j--) begin
            tab_lo[j] = tab_lo[j-1]; tab_hi[j] = tab_hi[j-1];
            tab_key[j] = tab_key[j-1]; tab_rule[j] = tab_rule[j-1];
         end
         tab_lo[0] = lo; tab_hi[0] = hi; tab_key[0] = key; tab_rule[0] = rule;
      endfunction

      function int first_subset(logic [63:0] lo, logic [63:0] hi);
         for (int i = 0; i < fill; i++)
            if (subset_of(tab_lo[i], tab_hi[i], lo, hi)) return i;
         return -1;
      endfunction

      // Keep entries for which hit is false; hit = superset or mask hit
      function int squeeze(logic [63:0] lo, logic [63:0] hi, bit by_mask);
         int j;
         int n;
         bit hit;
         j = 0;
         for (int i = 0; i < fill; i++) begin
            hit = by_mask ? (((tab_lo[i] & lo) != 0) || ((tab_hi[i] & hi) != 0))
                          : subset_of(lo, hi, tab_lo[i], tab_hi[i]);
            if (!hit) begin
               tab_lo[j] = tab_lo[i]; tab_hi[j] = tab_hi[i];
               tab_key[j] = tab_key[i]; tab_rule[j] = tab_rule[i];
               j++;
            end
         end
         n = fill - j;
         fill = j;
         return n;
      endfunction

      function void append(logic [63:0] lo, logic [63:0] hi, logic [6:0] key,
                           logic [2:0] rule);
         tab_lo[fill] = lo; tab_hi[fill] = hi; tab_key[fill] = key; tab_rule[fill] = rule;
         fill++;
      endfunction

      // Work out the results of one accepted transaction
      function void note_request(kind_type kind, logic [63:0] lo, logic [63:0] hi_in,
                                 logic [6:0] key, logic [2:0] rule);
         logic [63:0] hi;
         logic [63:0] rlo, rhi, ilo, ihi, clo, chi;
         int i, n, k;
         hi = hi_in & HIGH_MASK;
         case (kind)
            KIND_ADD: begin
               i = first_subset(lo, hi);
               if (i >= 0) begin
                  move_to_head(i);
                  queue_rsp(STAT_FALSE, 0, 0, 0, 0, 0, 1);
               end else begin
                  n = squeeze(lo, hi, 0);
                  if (fill >= TABLE_DEPTH) queue_rsp(STAT_FULL, n, 0, 0, 0, 0, 1);
                  else begin
                     append(lo, hi, key, rule);
                     queue_rsp(STAT_OK, n, 0, 0, 0, 0, 1);
                  end
               end
            end
            KIND_FORCE_ADD: begin
               if (fill >= TABLE_DEPTH) queue_rsp(STAT_FULL, 0, 0, 0, 0, 0, 1);
               else begin
                  append(lo, hi, key, rule);
                  queue_rsp(STAT_OK, 0, 0, 0, 0, 0, 1);
               end
            end
            KIND_RM_EXACT: begin
               for (i = 0; i < fill; i++)
                  if (tab_lo[i] == lo && tab_hi[i] == hi && tab_key[i] == key) break;
               if (i < fill) begin
                  queue_rsp(STAT_OK, 1, tab_lo[i], tab_hi[i], tab_key[i], tab_rule[i], 1);
                  for (int j = i + 1; j < fill; j++) begin
                     tab_lo[j-1] = tab_lo[j]; tab_hi[j-1] = tab_hi[j];
                     tab_key[j-1] = tab_key[j]; tab_rule[j-1] = tab_rule[j];
                  end
                  fill--;
               end else queue_rsp(STAT_FALSE, 0, 0, 0, 0, 0, 1);
            end
            KIND_RM_SUPER: begin
               n = squeeze(lo, hi, 0);
               queue_rsp(STAT_OK, n, 0, 0, 0, 0, 1);
            end
            KIND_RM_HIT: begin
               n = 0;
               for (i = 0; i < fill; i++)
                  if (((tab_lo[i] & lo) != 0) || ((tab_hi[i] & hi) != 0)) n++;
               if (n == 0) queue_rsp(STAT_OK, 0, 0, 0, 0, 0, 1);
               else begin
                  k = 0;
                  for (i = 0; i < fill; i++)
                     if (((tab_lo[i] & lo) != 0) || ((tab_hi[i] & hi) != 0)) begin
                        queue_rsp(STAT_OK, n, tab_lo[i], tab_hi[i], tab_key[i],
                                  tab_rule[i], k == n - 1);
                        k++;
                     end
                  void'(squeeze(lo, hi, 1));
               end
            end
            KIND_SUPER_TST: begin
               i = first_subset(lo, hi);
               if (i >= 0) move_to_head(i);
               queue_rsp(i >= 0 ? STAT_OK : STAT_FALSE, 0, 0, 0, 0, 0, 1);
            end
            KIND_SUB_TST: begin
               for (i = 0; i < fill; i++)
                  if (subset_of(lo, hi, tab_lo[i], tab_hi[i])) break;
               queue_rsp(i < fill ? STAT_OK : STAT_FALSE, 0, 0, 0, 0, 0, 1);
            end
            KIND_UNION, KIND_GREEDY: begin
               rlo = 0; rhi = 0; ilo = '1; ihi = HIGH_MASK;
               for (i = 0; i < fill; i++) begin
                  if (kind == KIND_UNION) begin
                     rlo |= tab_lo[i]; rhi |= tab_hi[i];
                  end else begin
                     clo = ilo & tab_lo[i]; chi = ihi & tab_hi[i];
                     if (clo != ilo || chi != ihi) begin
                        rlo |= tab_lo[i]; rhi |= tab_hi[i];
                        ilo = clo; ihi = chi;
                     end
                  end
               end
               queue_rsp(STAT_OK, 0, rlo, rhi, 0, 0, 1);
            end
            KIND_ISECT, KIND_KF_ISECT: begin
               rlo = '1; rhi = HIGH_MASK;
               for (i = 0; i < fill; i++) begin
                  clo = tab_lo[i]; chi = tab_hi[i];
                  if (kind == KIND_KF_ISECT && tab_key[i] < SET_BITS) begin
                     if (tab_key[i] < 64) clo[tab_key[i]] = 1'b0;
                     else chi[tab_key[i] - 64] = 1'b0;
                  end
                  rlo &= clo; rhi &= chi;
               end
               queue_rsp(STAT_OK, 0, rlo, rhi, 0, 0, 1);
            end
            default: queue_rsp(STAT_FALSE, 0, 0, 0, 0, 0, 1);
         endcase
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (pending_rsp.size() == 0) begin
            report_mismatch("result with nothing expected");
            return;
         end
         want = pending_rsp.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.removed !== want.removed)
            report_mismatch($sformatf("removed_count %0d, want %0d", got.removed, want.removed));
         if (got.lo !== want.lo)
            report_mismatch($sformatf("set_low %h, want %h", got.lo, want.lo));
         if (got.hi !== want.hi)
            report_mismatch($sformatf("set_high %h, want %h", got.hi, want.hi));
         if (got.key !== want.key)
            report_mismatch($sformatf("out_key %0d, want %0d", got.key, want.key));
         if (got.rule !== want.rule)
            report_mismatch($sformatf("out_rule %0d, want %0d", got.rule, want.rule));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [3:0]  req_kind;
   logic [63:0] req_carrier_low;
   logic [63:0] req_carrier_high;
   logic [6:0]  req_key_cell;
   logic [2:0]  req_rule_code;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_removed_count;
   logic [63:0] rsp_set_low;
   logic [63:0] rsp_set_high;
   logic [6:0]  rsp_out_key;
   logic [2:0]  rsp_out_rule;
   logic        rsp_last;

   carrier_table_scoreboard table_sb = new();
   int  cycle_count = 0;
   bit  no_gaps = 0;           // stretches of back-to-back transactions
   int  bit_pool[8];           // small universe so that subset relations are common

   minimal_carrier_set_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_carrier_low(req_carrier_low),
      .req_carrier_high(req_carrier_high), .req_key_cell(req_key_cell),
      .req_rule_code(req_rule_code), .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_removed_count(rsp_removed_count), .rsp_set_low(rsp_set_low),
      .rsp_set_high(rsp_set_high), .rsp_out_key(rsp_out_key),
      .rsp_out_rule(rsp_out_rule), .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: well beyond the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Note each transaction at the edge that takes it; values here are the
   // pre-edge ones, so the order against the driver does not matter
   always @(posedge clock) begin
      if (!reset && start && !busy)
         table_sb.note_request(req_kind, req_carrier_low, req_carrier_high,
                               req_key_cell, req_rule_code);
   end

   // Results are strobed for one cycle and cannot be held off
   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_strobe) begin
         got.status  = rsp_status;
         got.removed = rsp_removed_count;
         got.lo      = rsp_set_low;
         got.hi      = rsp_set_high;
         got.key     = rsp_out_key;
         got.rule    = rsp_out_rule;
         got.last    = rsp_last;
         table_sb.check_result(got);
      end
   end

   // Mostly short gaps, a few long ones; none at all during a no_gaps stretch
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Hold start high until the block takes the transaction. start is left high
   // afterwards so that a back-to-back transaction needs no second assignment.
   task automatic send_transaction(kind_type kind, logic [63:0] lo, logic [63:0] hi,
                                   logic [6:0] key, logic [2:0] rule);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_kind         <= kind;
      req_carrier_low  <= lo;
      req_carrier_high <= hi;
      req_key_cell     <= key;
      req_rule_code    <= rule;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and wait until every expected result has come, then let the
   // block settle
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (table_sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Carriers: sparse over a small pool, fully random, empty or full
   function automatic void pick_carrier(output logic [63:0] lo, output logic [63:0] hi);
      int r;
      r = $urandom_range(0, 99);
      lo = 0;
      hi = 0;
      if (r < 70) begin
         foreach (bit_pool[b])
            if ($urandom_range(0, 2) == 0) begin
               if (bit_pool[b] < 64) lo[bit_pool[b]] = 1'b1;
               else hi[bit_pool[b] - 64] = 1'b1;
            end
      end else if (r < 90) begin
         lo = {$urandom, $urandom};
         hi = {$urandom, $urandom};
      end else if (r < 95) begin
         lo = '1;
         hi = '1;
      end
   endfunction

   task automatic random_transaction();
      logic [63:0] lo, hi;
      logic [6:0]  key;
      logic [2:0]  rule;
      kind_type    kind;
      int          r;
      int          pick;
      r = $urandom_range(0, 99);
      if      (r < 30) kind = KIND_ADD;
      else if (r < 40) kind = KIND_FORCE_ADD;
      else if (r < 50) kind = KIND_RM_EXACT;
      else if (r < 55) kind = KIND_RM_SUPER;
      else if (r < 62) kind = KIND_RM_HIT;
      else if (r < 70) kind = KIND_SUPER_TST;
      else if (r < 78) kind = KIND_SUB_TST;
      else if (r < 82) kind = KIND_UNION;
      else if (r < 86) kind = KIND_GREEDY;
      else if (r < 91) kind = KIND_ISECT;
      else if (r < 97) kind = KIND_KF_ISECT;
      else kind = kind_type'($urandom_range(KIND_TOP + 1, 15));
      pick_carrier(lo, hi);
      key  = 7'($urandom_range(0, 127));
      rule = 3'($urandom_range(0, 7));
      // Aim exact removals at a stored entry most of the time
      pick = table_sb.fill;
      if (kind == KIND_RM_EXACT && pick > 0 && $urandom_range(0, 3) != 0) begin
         pick = $urandom_range(0, pick - 1);
         lo  = table_sb.tab_lo[pick];
         hi  = table_sb.tab_hi[pick];
         key = table_sb.tab_key[pick];
      end
      send_transaction(kind, lo, hi, key, rule);
   endtask

   initial begin
      logic [63:0] lo, hi;
      int          items;
      int          hits;
      bit          drained;

      reset            <= 1'b1;
      start            <= 1'b0;
      req_kind         <= KIND_ADD;
      req_carrier_low  <= '0;
      req_carrier_high <= '0;
      req_key_cell     <= '0;
      req_rule_code    <= '0;
      bit_pool[0] = 0;
      bit_pool[1] = 63;
      bit_pool[2] = 64;
      bit_pool[3] = 127;
      for (int b = 4; b < 8; b++) bit_pool[b] = $urandom_range(0, 127);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: union, intersection, tests, exact and mask removal on an empty table
      send_transaction(KIND_UNION,     '0, '0, 0, 0);
      send_transaction(KIND_GREEDY,    '0, '0, 0, 0);
      send_transaction(KIND_ISECT,     '0, '0, 0, 0);
      send_transaction(KIND_KF_ISECT,  '0, '0, 0, 0);
      send_transaction(KIND_RM_HIT,    '1, '1, 0, 0);
      send_transaction(KIND_RM_EXACT,  '0, '0, 0, 0);
      send_transaction(KIND_SUPER_TST, '1, '1, 0, 0);
      send_transaction(KIND_SUB_TST,   '0, '0, 0, 0);
      // Full carrier, then the empty carrier displaces it as a superset
      send_transaction(KIND_ADD,       '1, '1, 127, 7);
      send_transaction(KIND_ADD,       '0, '0, 0, 0);
      // Refused add: the empty carrier is a subset of anything
      send_transaction(KIND_ADD,       64'h20, '0, 5, 3);
      send_transaction(KIND_RM_SUPER,  '0, '0, 0, 0);
      // Key on both halves for the key-free intersection
      send_transaction(KIND_ADD,       64'h8000_0000_0000_0001, 64'h1, 63, 1);
      send_transaction(KIND_ADD,       64'h2, 64'h8000_0000_0000_0000, 127, 6);
      send_transaction(KIND_FORCE_ADD, 64'h3, 64'h1, 64, 2);
      send_transaction(KIND_KF_ISECT,  '0, '0, 0, 0);
      send_transaction(KIND_GREEDY,    '0, '0, 0, 0);
      send_transaction(KIND_SUPER_TST, 64'h3, 64'h1, 0, 0);
      send_transaction(KIND_SUB_TST,   64'h2, '0, 0, 0);
      send_transaction(KIND_RM_EXACT,  64'h3, 64'h1, 64, 0);
      send_transaction(kind_type'(KIND_TOP + 1), '1, '1, 127, 7);
      send_transaction(kind_type'(4'hF), '0, '0, 0, 0);
      send_transaction(KIND_RM_HIT,    '1, '1, 0, 0);

      // Random phase: mostly single operations, with occasional fill bursts
      // that drive the table to full and then remove by mask every entry with a bit set
      items = 0;
      drained = 1'b0;
      while (items < RANDOM_ITEMS) begin
         if (items % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         if (!drained && items >= RANDOM_ITEMS / 2) begin
            drain_results();
            drained = 1'b1;
         end
         if ($urandom_range(0, 39) == 0) begin
            for (int f = 0; f < TABLE_DEPTH + 2; f++) begin
               pick_carrier(lo, hi);
               send_transaction(KIND_FORCE_ADD, lo, hi, 7'($urandom_range(0, 127)),
                                3'($urandom_range(0, 7)));
            end
            hits = $urandom_range(2, 6);
            for (int f = 0; f < hits; f++) begin
               pick_carrier(lo, hi);
               send_transaction(KIND_ADD, lo, hi, 7'($urandom_range(0, 127)),
                                3'($urandom_range(0, 7)));
            end
            send_transaction(KIND_GREEDY, '0, '0, 0, 0);
            send_transaction(KIND_RM_HIT, '1, '1, 0, 0);
            items += TABLE_DEPTH + hits + 4;
         end else begin
            random_transaction();
            items++;
         end
      end

      drain_results();
      if (table_sb.mismatches == 0 && table_sb.pending_rsp.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         if (table_sb.pending_rsp.size() != 0)
            table_sb.report_mismatch($sformatf("%0d results never came",
                                               table_sb.pending_rsp.size()));
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/mcst_pkg.sv
rtl/mcst_ram.sv
rtl/mcst_cmp.sv
rtl/minimal_carrier_set_table.sv
tb/testbench.sv
